>>> hw/rtl/assert_macros.svh
// assertion macros for the port level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define TSIEVE_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define TSIEVE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  `TSIEVE_ASSERT(name, clk, rst, (ante) |=> (cons))

`endif

>>> hw/rtl/tsieve_pkg.sv
// package with widths, codes and shared types of the totient sieve table
package tsieve_pkg;

  localparam int NUM_W       = 17;
  localparam int NUM_LIMIT   = 1 << NUM_W;
  localparam int TABLE_SIZE  = 131072;
  localparam int TABLE_DEPTH = (TABLE_SIZE < NUM_LIMIT) ? TABLE_SIZE : NUM_LIMIT;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = ADDR_W + 1;
  localparam int STATUS_W    = 2;

  // newton steps for the inverse mod 2^17: 3 -> 6 -> 12 -> 24 good bits
  localparam int NEWTON_ITERS = 3;
  localparam int ITER_W       = 2;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd2;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [NUM_W-1:0]  data;
  } wr_req_t;

endpackage

>>> hw/rtl/tsieve_ram.sv
// generic simple dual port ram with registered read
module tsieve_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tsieve_inv.sv
// inverse of an odd value mod 2^17 by newton iteration, one multiply per cycle
module tsieve_inv (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tsieve_pkg::NUM_W-1:0] value,
  output logic                      done,
  output logic [tsieve_pkg::NUM_W-1:0] inv
);

  import tsieve_pkg::*;

  logic [NUM_W-1:0]  val;
  logic [NUM_W-1:0]  x;
  logic [NUM_W-1:0]  p;
  logic [ITER_W-1:0] iter;
  logic              phase;
  logic              running;
  logic [2*NUM_W-1:0] prod_vx;
  logic [2*NUM_W-1:0] prod_fix;

  assign prod_vx  = (2*NUM_W)'(val) * (2*NUM_W)'(x);
  assign prod_fix = (2*NUM_W)'(x) * (2*NUM_W)'(NUM_W'(2) - p);
  assign inv      = x;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      phase   <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        val     <= value;
        x       <= value;
        iter    <= '0;
        phase   <= 1'b0;
        running <= 1'b1;
      end else if (running) begin
        if (!phase) begin
          p     <= prod_vx[NUM_W-1:0];
          phase <= 1'b1;
        end else begin
          x     <= prod_fix[NUM_W-1:0];
          phase <= 1'b0;
          iter  <= iter + ITER_W'(1);
          if (iter == ITER_W'(NEWTON_ITERS - 1)) begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/tsieve_scale.sv
// read-modify-write pipe that scales an entry by (i-1)/i as t - t/i
module tsieve_scale (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          issue,
  input  logic [tsieve_pkg::ADDR_W-1:0] issue_addr,
  input  logic [tsieve_pkg::NUM_W-1:0]  rd_data,
  input  logic [tsieve_pkg::NUM_W-1:0]  inv,
  input  logic                          even,
  output tsieve_pkg::wr_req_t           wr,
  output logic                          busy
);

  import tsieve_pkg::*;

  logic               v1;
  logic [ADDR_W-1:0]  a1;
  logic               v2;
  logic [ADDR_W-1:0]  a2;
  logic [NUM_W-1:0]   t2;
  logic [NUM_W-1:0]   q2;
  logic [2*NUM_W-1:0] prod;

  // exact division: multiply by the inverse, or halve for the only even prime
  assign prod = (2*NUM_W)'(rd_data) * (2*NUM_W)'(inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= issue_addr;
    a2 <= a1;
    t2 <= rd_data;
    q2 <= even ? (rd_data >> 1) : prod[NUM_W-1:0];
  end

  assign wr.en   = v2;
  assign wr.addr = a2;
  assign wr.data = t2 - q2;
  assign busy    = v1 | v2;

endmodule

>>> hw/rtl/totient_sieve_table.sv
// top level of the totient sieve table: sieve sequencer, query path, result beat
//
//  channel  | handshake        | fields
//  ---------+------------------+-------------------------
//  input    | start, busy      | op, number
//  result   | done (strobe)    | totient, status
//
// a query takes one beat per cycle while idle; its result passes the registered
// read of the table ram and then the registered result outputs.
// a build holds busy through a fill of every entry, a check and a test of
// each candidate, the inverse unit for each prime, one write per multiple
// through the scaling pipe and its drain; the result beat follows at the end.
// rst clears the sequencer and the built flag; the table contents are left
// as they are and are rewritten by every build. the receiver cannot stall.
module totient_sieve_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [tsieve_pkg::NUM_W-1:0]      number,
  output logic                              done,
  output logic [tsieve_pkg::NUM_W-1:0]      totient,
  output logic [tsieve_pkg::STATUS_W-1:0]   status
);

  import tsieve_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FILL  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_TEST  = 3'd3;
  localparam logic [2:0] S_INV   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]          state;
  logic [IDX_W-1:0]    i;       // current sieve candidate
  logic [IDX_W-1:0]    j;       // fill index, then multiple of i
  logic                built;

  // query pipe
  logic                q_valid;
  logic [STATUS_W-1:0] q_status;

  // ram ports
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [NUM_W-1:0]    ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [NUM_W-1:0]    ram_rdata;

  logic                inv_start;
  logic                inv_done;
  logic [NUM_W-1:0]    inv_val;

  logic                scan_issue;
  wr_req_t             scale_wr;
  logic                scale_busy;
  logic                accept;
  logic                drain_write;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // prime test passes when the entry still holds its own index
  assign inv_start   = (state == S_TEST) && (ram_rdata == NUM_W'(i));
  assign scan_issue  = (state == S_SCAN) && (j < IDX_W'(TABLE_DEPTH));
  // prime's own entry becomes i-1 once its multiples are written back
  assign drain_write = (state == S_DRAIN) && !scale_busy;

  // read address: candidate, multiple, or the queried number
  always_comb begin
    case (state)
      S_CHECK: ram_raddr = i[ADDR_W-1:0];
      S_SCAN:  ram_raddr = j[ADDR_W-1:0];
      default: ram_raddr = number[ADDR_W-1:0];
    endcase
  end

  // write port: fill sweep, scaled entries, prime's own entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scale_wr.addr;
    ram_wdata = scale_wr.data;
    if (state == S_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = j[ADDR_W-1:0];
      ram_wdata = NUM_W'(j);
    end else if (scale_wr.en) begin
      ram_we = 1'b1;
    end else if (drain_write) begin
      ram_we    = 1'b1;
      ram_waddr = i[ADDR_W-1:0];
      ram_wdata = NUM_W'(i) - NUM_W'(1);
    end
  end

  tsieve_ram #(
    .WIDTH (NUM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsieve_inv u_inv (
    .clk   (clk),
    .rst   (rst),
    .start (inv_start),
    .value (NUM_W'(i)),
    .done  (inv_done),
    .inv   (inv_val)
  );

  tsieve_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .issue      (scan_issue),
    .issue_addr (j[ADDR_W-1:0]),
    .rd_data    (ram_rdata),
    .inv        (inv_val),
    .even       (~i[0]),
    .wr         (scale_wr),
    .busy       (scale_busy)
  );

  // sieve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      built <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && op == OP_BUILD) begin
            j     <= '0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          j <= j + IDX_W'(1);
          if (j == IDX_W'(TABLE_DEPTH - 1)) begin
            i     <= IDX_W'(2);
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (i >= IDX_W'(TABLE_DEPTH)) begin
            state <= S_DONE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (inv_start) begin
            state <= S_INV;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_CHECK;
          end
        end
        S_INV: begin
          if (inv_done) begin
            j     <= i << 1;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            j <= j + i;
          end else begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_write) begin
            i     <= i + IDX_W'(1);
            state <= S_CHECK;
          end
        end
        S_DONE: begin
          built <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query status is settled at acceptance; the table read lands in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= accept && (op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (!built) begin
      q_status <= ST_UNBUILT;
    end else if ((NUM_W + 1)'(number) >= (NUM_W + 1)'(TABLE_DEPTH)) begin
      q_status <= ST_RANGE;
    end else begin
      q_status <= ST_OK;
    end
  end

  // result beat: one cycle strobe, from a query or the end of a build
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid || (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid) begin
      totient <= (q_status == ST_OK) ? ram_rdata : '0;
      status  <= q_status;
    end else begin
      totient <= '0;
      status  <= ST_OK;
    end
  end

endmodule

>>> hw/rtl/tsieve_chk.sv
// port level checker for the totient sieve table, bound to the top level
`include "assert_macros.svh"

module tsieve_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            op,
  input logic [tsieve_pkg::NUM_W-1:0]    number,
  input logic                            done,
  input logic [tsieve_pkg::NUM_W-1:0]    totient,
  input logic [tsieve_pkg::STATUS_W-1:0] status
);

  import tsieve_pkg::*;

  logic q_accept;
  logic b_accept;
  logic num_low;

  assign q_accept = start && !busy && (op == OP_QUERY);
  assign b_accept = start && !busy && (op == OP_BUILD);
  assign num_low  = number[0];

  // an error beat carries no totient
  `TSIEVE_ASSERT(a_err_zero, clk, rst, (done && status != ST_OK) |-> (totient == '0))
  // every accepted query is answered with a done beat
  `TSIEVE_ASSERT(a_query_lat, clk, rst, q_accept |-> ##2 done)
  // a build holds the block busy
  `TSIEVE_ASSERT_NEXT(a_build_busy, clk, rst, b_accept, busy)
  // the beat that closes a build is a clean ok
  `TSIEVE_ASSERT(a_build_beat, clk, rst,
    (done && $past(busy)) |-> (status == ST_OK && totient == '0 && !$isunknown(num_low)))

endmodule

bind totient_sieve_table tsieve_chk u_chk (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .op      (op),
  .number  (number),
  .done    (done),
  .totient (totient),
  .status  (status)
);
